/* src/assert_macros.svh */
// Assertion helpers for the RTL, included by the burst core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  `ASSERT_PROP(label, clk, rst, !(cond), msg)
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* src/brbb_pkg.sv */
package brbb_pkg;

  localparam int CW = 7;
  localparam int BW = 8;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  localparam logic [CW-1:0] MAX_RESULTS = 7'd64;

  typedef struct packed {
    logic [1:0]    status;
    logic [BW-1:0] read_byte;
    logic [CW-1:0] count;
    logic [CW-1:0] fill_level;
    logic          last;
  } res_t;

endpackage

/* src/byte_ring_buffer_burst_core.sv */
// Circular byte FIFO with whole-burst admission. Write bytes, clears and
// ignored kinds leave the state idle, so a write burst streams at one byte
// per cycle unless the output stalls. A read request of n granted bytes is
// accepted, then its bytes go out at one per cycle, unless the output stalls,
// from the synchronous byte memory, whose registered read sits between
// acceptance and the first byte; the next item is taken after the last byte
// is handed to the output register. An input transfer is taken only while
// the output register is free or being emptied, and never in a cycle with a
// capacity write. Writing the capacity empties the buffer.
`include "assert_macros.svh"

module byte_ring_buffer_burst_core import brbb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // length[6:0], data_byte[14:7], zero[15]
  input  logic [2:0]  s_tuser,  // kind[1:0], burst_first[2]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // status[1:0], read_byte[9:2], count[16:10], fill_level[23:17]
  output logic        m_tlast
);

  localparam int PW = $clog2(DEPTH);

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_res;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [PW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_tvalid || m_tready;

  brbb_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  brbb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .kind        (s_tuser[1:0]),
    .length      (s_tdata[6:0]),
    .data_byte   (s_tdata[14:7]),
    .burst_first (s_tuser[2]),
    .burst_last  (s_tlast),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.fill_level, out_res.count, out_res.read_byte, out_res.status};
  assign m_tlast = out_res.last;

  `ASSERT_PROP(a_stall_blocks_input, clk, rst, (m_tvalid && !m_tready) |-> !s_tready, "input taken while result stalled")
  `ASSERT_NEVER(a_cfg_input_overlap, clk, rst, cfg_valid && cfg_ready && s_tvalid && s_tready, "capacity write and input transfer in one cycle")
  `ASSERT_PROP(a_empty_result, clk, rst, (m_tvalid && m_tdata[1:0] == ST_EMPTY) |-> (m_tlast && m_tdata[16:10] == 7'd0 && m_tdata[23:17] == 7'd0), "malformed empty-read result")

endmodule

/* src/brbb_ram.sv */
module brbb_ram #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/brbb_ctrl.sv */
module brbb_ctrl import brbb_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CW-1:0]            cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic [CW-1:0]            length,
  input  logic [BW-1:0]            data_byte,
  input  logic                     burst_first,
  input  logic                     burst_last,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [BW-1:0]            mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [BW-1:0]            mem_rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int AW = (PW + 1 > CW) ? PW + 1 : CW;
  localparam int CAP_MAX = (DEPTH < 127) ? DEPTH : 127;
  localparam int CAP_RST = (CAP_MAX < 64) ? CAP_MAX : 64;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic          state, state_next;
  logic [CW-1:0] cap, cap_next;
  logic [PW-1:0] wp, wp_next;
  logic [PW-1:0] rp, rp_next;
  logic [CW-1:0] stored, stored_next;
  logic          b_acc, b_acc_next;
  logic [CW-1:0] b_len, b_len_next;
  logic [CW-1:0] b_cnt, b_cnt_next;
  logic [CW-1:0] rem, rem_next;
  logic [CW-1:0] rd_n, rd_n_next;
  logic          accept;
  logic [CW-1:0] n;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CW-1:0] ec);
    logic [AW-1:0] inc;
    inc = AW'(p) + AW'(1);
    adv = (inc >= AW'(ec)) ? '0 : inc[PW-1:0];
  endfunction

  assign in_ready = (state == S_IDLE) && res_ready && !cfg_valid;
  assign accept   = in_valid && in_ready;
  assign mem_raddr = rp_next;

  always_comb begin
    state_next  = state;
    cap_next    = cap;
    wp_next     = wp;
    rp_next     = rp;
    stored_next = stored;
    b_acc_next  = b_acc;
    b_len_next  = b_len;
    b_cnt_next  = b_cnt;
    rem_next    = rem;
    rd_n_next   = rd_n;
    mem_we      = 1'b0;
    mem_waddr   = wp;
    mem_wdata   = data_byte;
    res_valid   = 1'b0;
    res         = '0;
    n = (length < stored) ? length : stored;
    if (n > MAX_RESULTS) begin
      n = MAX_RESULTS;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_WRITE: begin
              if (burst_first) begin
                b_acc_next = length <= (cap - stored);
                b_len_next = length;
                b_cnt_next = '0;
              end
              if (b_acc_next && (b_cnt_next < b_len_next) && (stored < cap)) begin
                mem_we      = 1'b1;
                wp_next     = adv(wp, cap);
                stored_next = stored + CW'(1);
                b_cnt_next  = b_cnt_next + CW'(1);
              end
              if (burst_last) begin
                res_valid      = 1'b1;
                res.status     = b_acc_next ? ST_OK : ST_REFUSED;
                res.count      = b_acc_next ? b_cnt_next : '0;
                res.fill_level = stored_next;
                res.last       = 1'b1;
                b_acc_next     = 1'b0;
                b_cnt_next     = '0;
              end
            end
            KIND_READ: begin
              if (stored == '0) begin
                res_valid      = 1'b1;
                res.status     = ST_EMPTY;
                res.last       = 1'b1;
              end else if (n == '0) begin
                res_valid      = 1'b1;
                res.status     = ST_OK;
                res.fill_level = stored;
                res.last       = 1'b1;
              end else begin
                rem_next   = n;
                rd_n_next  = n;
                state_next = S_READ;
              end
            end
            KIND_CLEAR: begin
              wp_next     = '0;
              rp_next     = '0;
              stored_next = '0;
              b_acc_next  = 1'b0;
              b_len_next  = '0;
              b_cnt_next  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (res_ready) begin
          res_valid      = 1'b1;
          res.status     = ST_OK;
          res.read_byte  = mem_rdata;
          res.count      = rd_n;
          res.fill_level = stored - CW'(1);
          res.last       = (rem == CW'(1));
          stored_next    = stored - CW'(1);
          rp_next        = adv(rp, cap);
          rem_next       = rem - CW'(1);
          if (rem == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    if (cfg_valid) begin
      if (cfg_data == '0) begin
        cap_next = CW'(1);
      end else if (AW'(cfg_data) > AW'(CAP_MAX)) begin
        cap_next = CW'(CAP_MAX);
      end else begin
        cap_next = cfg_data;
      end
      wp_next     = '0;
      rp_next     = '0;
      stored_next = '0;
      b_acc_next  = 1'b0;
      b_len_next  = '0;
      b_cnt_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cap    <= CW'(CAP_RST);
      wp     <= '0;
      rp     <= '0;
      stored <= '0;
      b_acc  <= 1'b0;
      b_len  <= '0;
      b_cnt  <= '0;
      rem    <= '0;
      rd_n   <= '0;
    end else begin
      state  <= state_next;
      cap    <= cap_next;
      wp     <= wp_next;
      rp     <= rp_next;
      stored <= stored_next;
      b_acc  <= b_acc_next;
      b_len  <= b_len_next;
      b_cnt  <= b_cnt_next;
      rem    <= rem_next;
      rd_n   <= rd_n_next;
    end
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  import brbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [1:0] kind;
    logic [6:0] length;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       drain;
  } fifo_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;

  byte_ring_buffer_burst_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  fifo_item_t pending_items[$];
  res_t       expected_results[$];
  fifo_item_t cur_item;
  logic       in_flight = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic       calm = 1'b0;

  // Predictor state of the ring.
  logic [7:0] ring [64];
  logic [5:0] wr_ptr = '0;
  logic [5:0] rd_ptr = '0;
  logic [6:0] fill = '0;
  logic       burst_open = 1'b0;
  logic [6:0] burst_len = '0;
  logic [6:0] burst_cnt = '0;
  logic [6:0] capacity_reg = 7'd64;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [6:0] eff_cap();
    if (capacity_reg == 7'd0) return 7'd1;
    if (capacity_reg > 7'd64) return 7'd64;
    return capacity_reg;
  endfunction

  function automatic logic [5:0] step_ptr(logic [5:0] p);
    logic [6:0] q;
    q = {1'b0, p} + 7'd1;
    return (q >= eff_cap()) ? 6'd0 : q[5:0];
  endfunction

  task automatic empty_ring();
    wr_ptr = '0;
    rd_ptr = '0;
    fill = '0;
    burst_open = 1'b0;
    burst_len = '0;
    burst_cnt = '0;
  endtask

  task automatic predict_fifo(fifo_item_t it);
    logic [6:0] cap;
    logic [6:0] n;
    res_t r;
    cap = eff_cap();
    r = '0;
    r.last = 1'b1;
    case (it.kind)
      KIND_WRITE: begin
        if (it.first) begin
          burst_open = (it.length <= cap - fill);
          burst_len = it.length;
          burst_cnt = '0;
        end
        if (burst_open && burst_cnt < burst_len && fill < cap) begin
          ring[wr_ptr] = it.data;
          wr_ptr = step_ptr(wr_ptr);
          fill = fill + 7'd1;
          burst_cnt = burst_cnt + 7'd1;
        end
        if (it.last) begin
          r.status = burst_open ? ST_OK : ST_REFUSED;
          r.count = burst_open ? burst_cnt : 7'd0;
          r.fill_level = fill;
          expected_results.push_back(r);
          burst_open = 1'b0;
          burst_cnt = '0;
        end
      end
      KIND_READ: begin
        if (fill == 7'd0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          n = (it.length < fill) ? it.length : fill;
          if (n > MAX_RESULTS) n = MAX_RESULTS;
          if (n == 7'd0) begin
            r.status = ST_OK;
            r.fill_level = fill;
            expected_results.push_back(r);
          end else begin
            for (int i = 0; i < n; i++) begin
              r.status = ST_OK;
              r.read_byte = ring[rd_ptr];
              rd_ptr = step_ptr(rd_ptr);
              fill = fill - 7'd1;
              r.count = n;
              r.fill_level = fill;
              r.last = (i + 1 == n);
              expected_results.push_back(r);
            end
          end
        end
      end
      KIND_CLEAR: empty_ring();
      default: ;
    endcase
  endtask

  task automatic add_item(logic [1:0] kind, logic [6:0] len, logic [7:0] data,
                          logic first, logic last);
    fifo_item_t it;
    it.kind = kind;
    it.length = len;
    it.data = data;
    it.first = first;
    it.last = last;
    it.drain = ($urandom_range(0, 39) == 0);
    pending_items.push_back(it);
  endtask

  task automatic add_burst(logic [6:0] decl, int nbytes, logic with_last);
    for (int i = 0; i < nbytes; i++) begin
      add_item(KIND_WRITE, (i == 0) ? decl : 7'($urandom), 8'($urandom), i == 0,
               with_last && (i == nbytes - 1));
    end
  endtask

  task automatic random_phase(int n);
    int pick;
    int sel;
    int cap;
    int decl;
    int nbytes;
    cap = eff_cap();
    while (pending_items.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) decl = $urandom_range(0, (cap < 8) ? cap : 8);
        else if (sel < 92) decl = $urandom_range(0, cap);
        else decl = $urandom_range(0, 127);
        nbytes = decl;
        if (decl > cap) nbytes = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) nbytes = decl + $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0 && decl > 1) nbytes = decl - 1;
        if (nbytes == 0) nbytes = 1;
        add_burst(7'(decl), nbytes, $urandom_range(0, 19) != 0);
      end else if (pick < 72) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) decl = $urandom_range(0, 8);
        else if (sel < 90) decl = $urandom_range(0, 64);
        else decl = $urandom_range(0, 127);
        add_item(KIND_READ, 7'(decl), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 77) begin
        add_item(KIND_CLEAR, 7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 82) begin
        add_item(KIND_IGNORED, 7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        add_item(KIND_WRITE, 7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_flight || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_reg = value;
    empty_ring();
  endtask

  // Input driver: one transfer per pending item, with a random gap after each.
  always @(posedge clk) begin
    logic v_next;
    v_next = s_tvalid;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_fifo(cur_item);
        in_flight = 1'b0;
        v_next = 1'b0;
        gap_left = draw_wait();
      end
      if (!in_flight) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain || expected_results.size() == 0)) begin
          cur_item = pending_items.pop_front();
          in_flight = 1'b1;
          v_next = 1'b1;
          s_tdata <= {1'b0, cur_item.data, cur_item.length};
          s_tuser <= {cur_item.first, cur_item.kind};
          s_tlast <= cur_item.last;
        end
      end
    end
    s_tvalid <= v_next;
  end

  // Result monitor: checks each transfer against the oldest expectation.
  always @(posedge clk) begin
    logic r_next;
    res_t got;
    res_t want;
    r_next = m_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.read_byte = m_tdata[9:2];
        got.count = m_tdata[16:10];
        got.fill_level = m_tdata[23:17];
        got.last = m_tlast;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result: status=%0d byte=%02h count=%0d fill=%0d last=%0b",
                     got.status, got.read_byte, got.count, got.fill_level, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"Mismatch: expected status=%0d byte=%02h count=%0d fill=%0d ",
                        "last=%0b, got status=%0d byte=%02h count=%0d fill=%0d last=%0b"},
                       want.status, want.read_byte, want.count, want.fill_level,
                       want.last, got.status, got.read_byte, got.count, got.fill_level,
                       got.last);
          end
        end
        stall_left = draw_wait();
        r_next = (stall_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        r_next = (stall_left == 0);
      end else begin
        r_next = 1'b1;
      end
    end
    m_tready <= r_next;
  end

  always @(posedge clk) begin
    cycle_count++;
    if ($urandom_range(0, 199) == 0) calm <= ~calm;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_item(KIND_READ, 7'd5, 8'h00, 1'b0, 1'b0);
    add_item(KIND_WRITE, 7'd3, 8'h00, 1'b1, 1'b0);
    add_item(KIND_WRITE, 7'h7f, 8'hff, 1'b0, 1'b0);
    add_item(KIND_WRITE, 7'h00, 8'ha5, 1'b0, 1'b1);
    add_item(KIND_READ, 7'd0, 8'hff, 1'b1, 1'b1);
    add_item(KIND_WRITE, 7'd1, 8'h5a, 1'b1, 1'b0);
    add_item(KIND_WRITE, 7'd1, 8'hc3, 1'b0, 1'b0);
    add_item(KIND_WRITE, 7'd1, 8'h3c, 1'b0, 1'b1);
    add_item(KIND_WRITE, 7'd64, 8'h12, 1'b1, 1'b0);
    add_item(KIND_WRITE, 7'd64, 8'h34, 1'b0, 1'b1);
    add_item(KIND_WRITE, 7'd9, 8'h77, 1'b0, 1'b0);
    add_item(KIND_WRITE, 7'd9, 8'h88, 1'b0, 1'b1);
    add_item(KIND_IGNORED, 7'h7f, 8'hff, 1'b1, 1'b1);
    add_item(KIND_READ, 7'h7f, 8'h00, 1'b0, 1'b0);
    add_item(KIND_WRITE, 7'd0, 8'h99, 1'b1, 1'b1);
    add_item(KIND_WRITE, 7'd1, 8'h80, 1'b1, 1'b1);
    add_item(KIND_CLEAR, 7'd0, 8'h00, 1'b0, 1'b0);
    add_item(KIND_READ, 7'd1, 8'h00, 1'b0, 1'b0);
    add_item(KIND_WRITE, 7'd60, 8'h01, 1'b1, 1'b1);
    add_item(KIND_READ, 7'd64, 8'h00, 1'b0, 1'b0);
    pending_items[$].drain = 1'b1;
    // A new first byte restarts the open burst's count; bytes already written stay in the buffer.
    add_item(KIND_WRITE, 7'd2, 8'h11, 1'b1, 1'b0);
    add_item(KIND_WRITE, 7'd5, 8'h22, 1'b1, 1'b0);
    add_item(KIND_WRITE, 7'd5, 8'h33, 1'b0, 1'b1);
    add_item(KIND_READ, 7'd2, 8'h00, 1'b0, 1'b0);
    wait_idle();

    random_phase(60);
    pending_items[0].drain = 1'b1;
    wait_idle();
    write_capacity(7'd1);
    random_phase(50);
    wait_idle();
    write_capacity(7'd127);
    random_phase(60);
    wait_idle();
    write_capacity(7'd0);
    random_phase(30);
    wait_idle();
    write_capacity(7'($urandom_range(2, 63)));
    random_phase(45);
    wait_idle();
    write_capacity(7'd64);
    random_phase(45);
    wait_idle();
    write_capacity(7'($urandom_range(1, 127)));
    random_phase(40);
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
